[rtl/core/sce_pkg.sv]
// sce_pkg: types and codes shared by the stack CPU execute block.
// Holds the input/output item structs and the instruction field codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sce_pkg;

    typedef struct packed {
        logic [31:0] instr;
        logic [31:0] word_at_top;
        logic [7:0]  byte_at_top;
    } t_exec_in;

    typedef struct packed {
        logic [31:0] fetch_addr;
        logic        store_en;
        logic        store_byte;
        logic [31:0] store_addr;
        logic [31:0] store_data;
        logic [31:0] new_top;
        logic        illegal;
    } t_exec_out;

    // instruction kinds, bits 30..29
    localparam logic [1:0] KIND_JMP  = 2'd0;
    localparam logic [1:0] KIND_JZ   = 2'd1;
    localparam logic [1:0] KIND_CALL = 2'd2;
    localparam logic [1:0] KIND_ALU  = 2'd3;

    // stack moves
    localparam logic [2:0] STK_PUSH = 3'd1;
    localparam logic [2:0] STK_POP  = 3'd2;

    // A sources
    localparam logic [2:0] ASEL_DTOP  = 3'd0;
    localparam logic [2:0] ASEL_DSEC  = 3'd1;
    localparam logic [2:0] ASEL_RTOP  = 3'd2;
    localparam logic [2:0] ASEL_RSEC  = 3'd3;
    localparam logic [2:0] ASEL_ID    = 3'd4;
    localparam logic [2:0] ASEL_X     = 3'd5;
    localparam logic [2:0] ASEL_DPTR  = 3'd6;
    localparam logic [2:0] ASEL_MUL   = 3'd7;

    // B sources
    localparam logic [1:0] BSEL_X    = 2'd0;
    localparam logic [1:0] BSEL_DTOP = 2'd1;
    localparam logic [1:0] BSEL_DSEC = 2'd2;
    localparam logic [1:0] BSEL_RTOP = 2'd3;

    // ALU ops
    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_SUB  = 5'd1;
    localparam logic [4:0] OP_AND  = 5'd2;
    localparam logic [4:0] OP_OR   = 5'd3;
    localparam logic [4:0] OP_XOR  = 5'd4;
    localparam logic [4:0] OP_NOT  = 5'd5;
    localparam logic [4:0] OP_EQ   = 5'd6;
    localparam logic [4:0] OP_LT   = 5'd7;
    localparam logic [4:0] OP_ULT  = 5'd8;
    localparam logic [4:0] OP_SHR  = 5'd9;
    localparam logic [4:0] OP_SHL  = 5'd10;
    localparam logic [4:0] OP_READ = 5'b01011;
    localparam logic [4:0] OP_QMUL = 5'b01100;
    localparam logic [4:0] OP_QADD = 5'b01101;
    localparam logic [4:0] OP_QSUB = 5'b01110;

    localparam logic [31:0] Q31_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q31_MIN = 32'h8000_0000;

    localparam logic [1:0] CFG_CORE_ID = 2'd0;

endpackage
`default_nettype wire

[rtl/core/stack_cpu_execute.sv]
// stack_cpu_execute: execute stage of a two-stack processor core.
// Depends on sce_pkg (item structs, instruction codes).
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_data): one transfer carries
//    the fetched instruction plus the memory word and byte at the address in
//    the current data stack top (o_out_data.new_top of the previous result).
//  - Output channel (o_out_valid / i_out_stall / o_out_data): one result per
//    instruction: next fetch address, store request, new top and illegal flag.
//  - Config port (APB): one register, core_id, at byte address 0.
//  - Results are registered: each appears the cycle after its instruction transfer.
//  - Throughput: one instruction per cycle unless stalled. Both stacks live
//    in synchronous RAMs that are read every cycle one entry below the next
//    pointer, so a pop finds its value already registered; top and second sit in flops.
//  - The multiply pipe advances once per legal instruction, so its
//    delay is counted in instructions, not cycles.
//  - When the receiver stalls, the result register holds and the input is
//    stalled in the same cycle; nothing is lost or repeated.
//  - Reset clears pc, stacks, multiply pipe and core_id. Stack entries carry
//    valid flops that reset clears at once, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module stack_cpu_execute
    import sce_pkg::*;
#(
    parameter int DATA_STACK_DEPTH   = 16,
    parameter int RETURN_STACK_DEPTH = 16,
    parameter int MUL_LATENCY        = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_exec_in    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_exec_out        o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int DPW = (DATA_STACK_DEPTH > 1) ? $clog2(DATA_STACK_DEPTH) : 1;
    localparam int RPW = (RETURN_STACK_DEPTH > 1) ? $clog2(RETURN_STACK_DEPTH) : 1;
    localparam logic [DPW-1:0] DLAST = DPW'(DATA_STACK_DEPTH - 1);
    localparam logic [RPW-1:0] RLAST = RPW'(RETURN_STACK_DEPTH - 1);

    // architectural registers
    logic [31:0]    r_pc, r_dtop, r_dsec, r_rtop, r_rsec, r_core_id;
    logic [DPW-1:0] r_dptr;
    logic [RPW-1:0] r_rptr;
    logic [31:0]    r_mul [MUL_LATENCY];

    // stack memories and their valid flags
    logic [31:0] dmem [DATA_STACK_DEPTH];
    logic [31:0] rmem [RETURN_STACK_DEPTH];
    logic [DATA_STACK_DEPTH-1:0]   r_dvld;
    logic [RETURN_STACK_DEPTH-1:0] r_rvld;
    logic [31:0] r_drd, r_rrd;
    logic        r_drd_vld, r_rrd_vld;

    // result register
    logic      r_out_valid;
    t_exec_out r_out_data;

    logic        accept, cfg_wr;
    logic [31:0] ins, body;
    logic [1:0]  kind;
    logic        lit, is_alu, bad_op, legal;
    logic [4:0]  x, op;
    logic [2:0]  dst, rst, asel;
    logic [1:0]  bsel;
    logic        bmem, nt, tr, tn, rpc;
    logic [31:0] a, b, r, pc4, popped_d, popped_r, q;
    logic signed [63:0] prod;
    logic signed [32:0] qsum, qdif;
    logic        d_push, d_pop, r_push, r_pop;
    logic [DPW-1:0] n_dptr, d_rd_addr;
    logic [RPW-1:0] n_rptr, r_rd_addr;
    logic [31:0] n_pc, n_dtop, n_dsec, n_rtop, n_rsec;
    t_exec_out   n_out;

    // hold the input while a finished result waits on a stalled receiver
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == CFG_CORE_ID[0]) ? r_core_id : 32'd0;

    // decode
    assign ins    = i_in_data.instr;
    assign body   = {3'd0, ins[28:0]};
    assign kind   = ins[30:29];
    assign lit    = ins[31];
    assign is_alu = ~lit & (kind == KIND_ALU);
    assign x      = ins[4:0];
    assign dst    = ins[7:5];
    assign rst    = ins[10:8];
    assign bmem   = ins[14];
    assign nt     = ins[15];
    assign tr     = ins[16];
    assign tn     = ins[17];
    assign rpc    = ins[18];
    assign op     = ins[23:19];
    assign bsel   = ins[25:24];
    assign asel   = ins[28:26];
    assign bad_op = is_alu & (op > OP_QSUB);
    assign legal  = accept & ~bad_op;
    assign pc4    = r_pc + 32'd4;

    // popped values: registered RAM read one below the current pointer
    assign popped_d = r_drd_vld ? r_drd : 32'd0;
    assign popped_r = r_rrd_vld ? r_rrd : 32'd0;

    always_comb begin
        case (asel)
            ASEL_DTOP: a = r_dtop;
            ASEL_DSEC: a = r_dsec;
            ASEL_RTOP: a = r_rtop;
            ASEL_RSEC: a = r_rsec;
            ASEL_ID:   a = r_core_id;
            ASEL_X:    a = {27'd0, x};
            ASEL_DPTR: a = 32'(r_dptr);
            // read the next-to-last pipe stage; the last stage is never read
            default:   a = r_mul[MUL_LATENCY-2];
        endcase
        case (bsel)
            BSEL_X:    b = {27'd0, x};
            BSEL_DTOP: b = r_dtop;
            BSEL_DSEC: b = r_dsec;
            default:   b = r_rtop;
        endcase
    end

    assign prod = $signed(a) * $signed(b);
    assign q    = ((a == Q31_MIN) && (b == Q31_MIN)) ? Q31_MAX : prod[62:31];
    assign qsum = {a[31], a} + {b[31], b};
    assign qdif = {a[31], a} - {b[31], b};

    always_comb begin
        r = r_dtop;
        case (op)
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_NOT:  r = ~a;
            OP_EQ:   r = (a == b) ? '1 : '0;
            OP_LT:   r = ($signed(a) < $signed(b)) ? '1 : '0;
            OP_ULT:  r = (a < b) ? '1 : '0;
            OP_SHR:  r = a >> b[4:0];
            OP_SHL:  r = a << b[4:0];
            OP_READ: r = bmem ? {24'd0, i_in_data.byte_at_top} : i_in_data.word_at_top;
            OP_QADD: begin
                if (qsum[32] != qsum[31]) r = qsum[32] ? Q31_MIN : Q31_MAX;
                else r = qsum[31:0];
            end
            OP_QSUB: begin
                if (qdif[32] != qdif[31]) r = qdif[32] ? Q31_MIN : Q31_MAX;
                else r = qdif[31:0];
            end
            default: r = r_dtop;
        endcase
    end

    assign d_push = lit | (is_alu & (dst == STK_PUSH));
    assign d_pop  = (~lit & (kind == KIND_JZ)) | (is_alu & (dst == STK_POP));
    assign r_push = (~lit & (kind == KIND_CALL)) | (is_alu & (rst == STK_PUSH));
    assign r_pop  = is_alu & (rst == STK_POP);

    // next state of the instruction
    always_comb begin
        n_pc   = r_pc;
        n_dtop = r_dtop;
        n_dsec = r_dsec;
        n_rtop = r_rtop;
        n_rsec = r_rsec;
        n_dptr = r_dptr;
        n_rptr = r_rptr;
        if (legal) begin
            if (d_push) begin
                n_dptr = (r_dptr == DLAST) ? '0 : r_dptr + 1'b1;
                n_dsec = r_dtop;
            end else if (d_pop) begin
                n_dptr = (r_dptr == '0) ? DLAST : r_dptr - 1'b1;
                n_dsec = popped_d;
            end
            if (r_push) begin
                n_rptr = (r_rptr == RLAST) ? '0 : r_rptr + 1'b1;
                n_rsec = r_rtop;
            end else if (r_pop) begin
                n_rptr = (r_rptr == '0) ? RLAST : r_rptr - 1'b1;
                n_rsec = popped_r;
                n_rtop = r_rsec;
            end
            if (lit) begin
                n_dtop = {1'b0, ins[30:0]};
                n_pc   = pc4;
            end else begin
                case (kind)
                    KIND_JMP: n_pc = body;
                    KIND_JZ: begin
                        n_pc   = (r_dtop != 32'd0) ? pc4 : body;
                        n_dtop = r_dsec;
                    end
                    KIND_CALL: begin
                        n_rtop = pc4;
                        n_pc   = body;
                    end
                    default: begin
                        n_pc = rpc ? r_rtop : pc4;
                        if (tn) n_dsec = r_dtop;
                        if (tr) n_rtop = r_dtop;
                        n_dtop = r;
                    end
                endcase
            end
        end
    end

    // read one entry below the next pointer: what a pop in the next cycle needs
    assign d_rd_addr = (n_dptr == '0) ? DLAST : n_dptr - 1'b1;
    assign r_rd_addr = (n_rptr == '0) ? RLAST : n_rptr - 1'b1;

    // result item
    always_comb begin
        n_out            = '0;
        n_out.fetch_addr = bad_op ? r_pc : n_pc;
        n_out.new_top    = bad_op ? r_dtop : n_dtop;
        n_out.illegal    = bad_op;
        if (is_alu && !bad_op && nt) begin
            n_out.store_en   = 1'b1;
            n_out.store_byte = bmem;
            n_out.store_addr = r_dtop;
            n_out.store_data = bmem ? {24'd0, r_dsec[7:0]} : r_dsec;
        end
    end

    // stack RAMs: write the new entry, read below the next pointer
    always_ff @(posedge i_clk) begin
        if (legal && (d_push || (is_alu && tn))) dmem[n_dptr] <= r_dtop;
        r_drd <= dmem[d_rd_addr];
        if (legal && r_push) rmem[n_rptr] <= r_rtop;
        r_rrd <= rmem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_dtop      <= '0;
            r_dsec      <= '0;
            r_rtop      <= '0;
            r_rsec      <= '0;
            r_dptr      <= '0;
            r_rptr      <= '0;
            r_core_id   <= '0;
            r_dvld      <= '0;
            r_rvld      <= '0;
            r_drd_vld   <= 1'b0;
            r_rrd_vld   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MUL_LATENCY; i++) r_mul[i] <= '0;
        end else begin
            r_pc      <= n_pc;
            r_dtop    <= n_dtop;
            r_dsec    <= n_dsec;
            r_rtop    <= n_rtop;
            r_rsec    <= n_rsec;
            r_dptr    <= n_dptr;
            r_rptr    <= n_rptr;
            r_drd_vld <= r_dvld[d_rd_addr];
            r_rrd_vld <= r_rvld[r_rd_addr];
            if (legal && (d_push || (is_alu && tn))) r_dvld[n_dptr] <= 1'b1;
            if (legal && r_push) r_rvld[n_rptr] <= 1'b1;
            if (cfg_wr && paddr[2] == CFG_CORE_ID[0]) r_core_id <= pwdata;
            // advance the multiply pipe once per legal instruction
            if (legal) begin
                for (int i = MUL_LATENCY - 1; i >= 1; i--) r_mul[i] <= r_mul[i-1];
                if (is_alu && op == OP_QMUL) r_mul[0] <= q;
            end
            if (accept) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_out_data <= n_out;
    end

endmodule
`default_nettype wire
